### hw/rtl/wlh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wlh_pkg
// Shared types, codes and constants of the water level pump controller.
// ----------------------------------------------------------------------------
package wlh_pkg;

    localparam int NUM_CHANNELS_DEF = 20;
    localparam int LEVEL_STEP_DEF   = 5;
    localparam int FIFO_DEPTH_DEF   = 2;

    localparam int CFG_IDX_W = 3;

    localparam logic [6:0]  LEVEL_MAX_PCT = 7'd100;
    localparam logic [15:0] DUR_BASE_MS   = 16'd1000;
    localparam logic [15:0] DUR_STEP_MS   = 16'd100;

    localparam logic [7:0]  TOUCH_THRESHOLD_RST = 8'd100;
    localparam logic [6:0]  LOW_PCT_RST         = 7'd30;
    localparam logic [6:0]  HIGH_PCT_RST        = 7'd70;
    localparam logic [5:0]  HYST_PCT_RST        = 6'd5;
    localparam logic [15:0] MAX_MS_RST          = 16'd10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOUCH_THRESHOLD = 3'd0,
        CFG_LOW_LEVEL       = 3'd1,
        CFG_HIGH_LEVEL      = 3'd2,
        CFG_HYSTERESIS      = 3'd3,
        CFG_MAX_PUMP_MS     = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        FAULT_NONE    = 2'd0,
        FAULT_TIMEOUT = 2'd1,
        FAULT_ZERO    = 2'd2
    } fault_t;

    typedef enum logic [1:0] {
        PUMP_NONE   = 2'd0,
        PUMP_INLET  = 2'd1,
        PUMP_OUTLET = 2'd2
    } pump_t;

    // frame summary handed from front to back
    typedef struct packed {
        logic [6:0] level;
        fault_t     fault;
    } wlh_frame_t;

    // settings used by the back end
    typedef struct packed {
        logic [6:0]  low_pct;
        logic [6:0]  high_pct;
        logic [5:0]  hyst_pct;
        logic [15:0] max_ms;
    } wlh_cfg_t;

endpackage
`default_nettype wire

### hw/rtl/wlh_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wlh_front
// Takes channel readings, tracks the touched run and faults, and pushes one
// frame summary into the queue at the marked last channel.
// ----------------------------------------------------------------------------
module wlh_front #(
    parameter int NUM_CHANNELS = 20,
    parameter int LEVEL_STEP   = 5
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [7:0]             sensor_reading,
    input  wire logic                   bus_timeout,
    input  wire logic                   frame_last,
    input  wire logic [7:0]             touch_threshold,
    output logic                        push_valid,
    output wlh_pkg::wlh_frame_t         push_data,
    input  wire logic                   push_ready
);
    import wlh_pkg::*;

    localparam int RL_W   = $clog2(NUM_CHANNELS + 1);
    localparam int PROD_W = RL_W + 7;

    logic [RL_W-1:0]   run_length_reg, run_length_next;
    logic              run_broken_reg, run_broken_next;
    logic              any_nonzero_reg, any_nonzero_next;
    logic              timeout_seen_reg, timeout_seen_next;
    logic              accept;
    logic              touched;
    logic [RL_W-1:0]   rl_upd;
    logic              broken_upd;
    logic              nonzero_upd;
    logic              timeout_upd;
    logic [PROD_W-1:0] level_prod;

    assign accept   = in_valid && push_ready;
    assign in_stall = !push_ready;
    assign touched  = sensor_reading > touch_threshold;

    always_comb
    begin
        rl_upd      = run_length_reg;
        broken_upd  = run_broken_reg;
        nonzero_upd = any_nonzero_reg || (sensor_reading != 8'd0);
        timeout_upd = timeout_seen_reg || bus_timeout;
        if (touched)
        begin
            if (!run_broken_reg && (run_length_reg < RL_W'(NUM_CHANNELS)))
                rl_upd = run_length_reg + RL_W'(1);
        end
        else
        begin
            broken_upd = 1'b1;
        end

        level_prod = PROD_W'(rl_upd) * PROD_W'(LEVEL_STEP);

        push_valid = accept && frame_last;
        push_data.level = (level_prod > PROD_W'(LEVEL_MAX_PCT)) ? LEVEL_MAX_PCT
                                                                : level_prod[6:0];
        if (timeout_upd)
            push_data.fault = FAULT_TIMEOUT;
        else if (!nonzero_upd)
            push_data.fault = FAULT_ZERO;
        else
            push_data.fault = FAULT_NONE;

        run_length_next   = run_length_reg;
        run_broken_next   = run_broken_reg;
        any_nonzero_next  = any_nonzero_reg;
        timeout_seen_next = timeout_seen_reg;
        if (accept)
        begin
            if (frame_last)
            begin
                run_length_next   = '0;
                run_broken_next   = 1'b0;
                any_nonzero_next  = 1'b0;
                timeout_seen_next = 1'b0;
            end
            else
            begin
                run_length_next   = rl_upd;
                run_broken_next   = broken_upd;
                any_nonzero_next  = nonzero_upd;
                timeout_seen_next = timeout_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_length_reg   <= '0;
            run_broken_reg   <= 1'b0;
            any_nonzero_reg  <= 1'b0;
            timeout_seen_reg <= 1'b0;
        end
        else
        begin
            run_length_reg   <= run_length_next;
            run_broken_reg   <= run_broken_next;
            any_nonzero_reg  <= any_nonzero_next;
            timeout_seen_reg <= timeout_seen_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        run_length_reg <= RL_W'(NUM_CHANNELS))
        else $error("run length beyond channel count");
    a_run_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (run_broken_reg && !(accept && frame_last)) |=> $stable(run_length_reg))
        else $error("run length grew after a break");
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && frame_last) |=> (run_length_reg == '0 && !timeout_seen_reg))
        else $error("frame state not cleared after last item");
`endif

endmodule
`default_nettype wire

### hw/rtl/wlh_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wlh_fifo
// Short queue of frame summaries between the front and the back end.
// ----------------------------------------------------------------------------
module wlh_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push_valid,
    input  wire wlh_pkg::wlh_frame_t    push_data,
    output logic                        push_ready,
    output logic                        pop_valid,
    output wlh_pkg::wlh_frame_t         pop_data,
    input  wire logic                   pop_ready
);
    import wlh_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wlh_frame_t       entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_data;
    end

`ifndef NO_ASSERTIONS
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count overflow");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count did not follow push");
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("pointers differ on empty queue");
`endif

endmodule
`default_nettype wire

### hw/rtl/wlh_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wlh_back
// Applies hysteresis to each frame summary, updates the pump latches,
// works out the run duration and holds the result item for the consumer.
// ----------------------------------------------------------------------------
module wlh_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   pop_valid,
    input  wire wlh_pkg::wlh_frame_t    pop_data,
    output logic                        pop_ready,
    input  wire wlh_pkg::wlh_cfg_t      cfg,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [6:0]                  level_percent,
    output logic [1:0]                  pump_start,
    output logic [15:0]                 pump_duration_ms,
    output logic                        emergency_stop,
    output logic [1:0]                  fault_code
);
    import wlh_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic [6:0]  level_reg;
    pump_t       pump_reg;
    logic [15:0] dur_reg;
    logic        estop_reg;
    fault_t      fault_reg;
    logic        inlet_latched_reg, inlet_latched_next;
    logic        outlet_latched_reg, outlet_latched_next;

    logic        take;
    logic        ok;
    logic [6:0]  lv;
    logic [7:0]  lv_plus_hy;
    logic [7:0]  lo_plus_hy;
    logic [7:0]  hi_plus_hy;
    logic        inlet_due;
    logic        inlet_off;
    logic        outlet_due;
    logic        outlet_off;
    logic        start_inlet;
    logic        start_outlet;
    logic [6:0]  target;
    logic [6:0]  dev;
    logic [15:0] dur_raw;
    pump_t       pump_d;
    logic [15:0] dur_d;

    assign take      = pop_valid && (!out_valid_reg || !out_stall);
    assign pop_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        ok         = pop_data.fault == FAULT_NONE;
        lv         = ok ? pop_data.level : 7'd0;
        lv_plus_hy = 8'(lv) + 8'(cfg.hyst_pct);
        lo_plus_hy = 8'(cfg.low_pct) + 8'(cfg.hyst_pct);
        hi_plus_hy = 8'(cfg.high_pct) + 8'(cfg.hyst_pct);
        inlet_due  = lv_plus_hy < 8'(cfg.low_pct);
        inlet_off  = 8'(lv) > lo_plus_hy;
        outlet_due = 8'(lv) > hi_plus_hy;
        outlet_off = lv_plus_hy < 8'(cfg.high_pct);

        start_inlet  = ok && inlet_due && !inlet_latched_reg;
        start_outlet = ok && outlet_due && !outlet_latched_reg && !start_inlet;

        target  = start_inlet ? cfg.low_pct : cfg.high_pct;
        dev     = (lv >= target) ? (lv - target) : (target - lv);
        dur_raw = DUR_BASE_MS + 16'(dev) * DUR_STEP_MS;

        if (start_inlet)
            pump_d = PUMP_INLET;
        else if (start_outlet)
            pump_d = PUMP_OUTLET;
        else
            pump_d = PUMP_NONE;

        if (start_inlet || start_outlet)
            dur_d = (dur_raw > cfg.max_ms) ? cfg.max_ms : dur_raw;
        else
            dur_d = 16'd0;

        inlet_latched_next  = inlet_latched_reg;
        outlet_latched_next = outlet_latched_reg;
        if (take && ok)
        begin
            if (inlet_due)
            begin
                if (start_inlet)
                    inlet_latched_next = 1'b1;
            end
            else if (inlet_off)
            begin
                inlet_latched_next = 1'b0;
            end

            if (outlet_due)
            begin
                if (start_outlet)
                    outlet_latched_next = 1'b1;
            end
            else if (outlet_off)
            begin
                outlet_latched_next = 1'b0;
            end
        end

        if (take)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg      <= 1'b0;
            inlet_latched_reg  <= 1'b0;
            outlet_latched_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg      <= out_valid_next;
            inlet_latched_reg  <= inlet_latched_next;
            outlet_latched_reg <= outlet_latched_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            level_reg <= lv;
            pump_reg  <= pump_d;
            dur_reg   <= dur_d;
            estop_reg <= !ok;
            fault_reg <= pop_data.fault;
        end
    end

    assign out_valid        = out_valid_reg;
    assign level_percent    = level_reg;
    assign pump_start       = pump_reg;
    assign pump_duration_ms = dur_reg;
    assign emergency_stop   = estop_reg;
    assign fault_code       = fault_reg;

`ifndef NO_ASSERTIONS
    a_fault_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && estop_reg) |-> (pump_reg == PUMP_NONE && level_reg == 7'd0))
        else $error("pump started or level shown on fault");
    a_estop_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (estop_reg == (fault_reg != FAULT_NONE)))
        else $error("emergency stop disagrees with fault code");
    a_idle_dur: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && pump_reg == PUMP_NONE) |-> (dur_reg == 16'd0))
        else $error("duration without pump start");
    a_start_sets_latch: assert property (@(posedge clk) disable iff (!rst_n)
        (take && pump_d == PUMP_INLET) |=> inlet_latched_reg)
        else $error("inlet start did not set latch");
`endif

endmodule
`default_nettype wire

### hw/rtl/water_level_hysteresis_pump_control.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// water_level_hysteresis_pump_control
// Water level monitor: touch channel frames in, pump commands out.
//
// One channel item is taken every clock cycle while the summary queue has
// room. Items before the last channel produce nothing; the last channel
// pushes a frame summary (level and fault) into a FIFO_DEPTH deep queue, and
// the back end pops it and turns it into a registered result item. The
// back end handles one frame per cycle unless the result output is held off,
// so the input stalls only when the queue fills while that output is held
// off. No clearing pass after reset: the block takes items from the first cycle.
// ----------------------------------------------------------------------------
module water_level_hysteresis_pump_control #(
    parameter int NUM_CHANNELS = wlh_pkg::NUM_CHANNELS_DEF,
    parameter int LEVEL_STEP   = wlh_pkg::LEVEL_STEP_DEF,
    parameter int FIFO_DEPTH   = wlh_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [7:0]                      sensor_reading,
    input  wire logic                            bus_timeout,
    input  wire logic                            frame_last,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [6:0]                           level_percent,
    output logic [1:0]                           pump_start,
    output logic [15:0]                          pump_duration_ms,
    output logic                                 emergency_stop,
    output logic [1:0]                           fault_code,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [wlh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [15:0]                     cfg_data
);
    import wlh_pkg::*;

    logic [7:0] touch_threshold_reg;
    wlh_cfg_t   cfg_reg;
    logic       cfg_wr;

    wlh_frame_t push_data;
    logic       push_valid;
    logic       push_ready;
    wlh_frame_t pop_data;
    logic       pop_valid;
    logic       pop_ready;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touch_threshold_reg <= TOUCH_THRESHOLD_RST;
            cfg_reg.low_pct     <= LOW_PCT_RST;
            cfg_reg.high_pct    <= HIGH_PCT_RST;
            cfg_reg.hyst_pct    <= HYST_PCT_RST;
            cfg_reg.max_ms      <= MAX_MS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_TOUCH_THRESHOLD: touch_threshold_reg <= cfg_data[7:0];
                CFG_LOW_LEVEL:       cfg_reg.low_pct     <= cfg_data[6:0];
                CFG_HIGH_LEVEL:      cfg_reg.high_pct    <= cfg_data[6:0];
                CFG_HYSTERESIS:      cfg_reg.hyst_pct    <= cfg_data[5:0];
                CFG_MAX_PUMP_MS:     cfg_reg.max_ms      <= cfg_data;
                default:             ;
            endcase
        end
    end

    wlh_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .LEVEL_STEP   (LEVEL_STEP)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .sensor_reading  (sensor_reading),
        .bus_timeout     (bus_timeout),
        .frame_last      (frame_last),
        .touch_threshold (touch_threshold_reg),
        .push_valid      (push_valid),
        .push_data       (push_data),
        .push_ready      (push_ready)
    );

    wlh_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    wlh_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .pop_valid        (pop_valid),
        .pop_data         (pop_data),
        .pop_ready        (pop_ready),
        .cfg              (cfg_reg),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .level_percent    (level_percent),
        .pump_start       (pump_start),
        .pump_duration_ms (pump_duration_ms),
        .emergency_stop   (emergency_stop),
        .fault_code       (fault_code)
    );

`ifndef NO_ASSERTIONS
    a_cfg_hold_thr: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_wr |=> $stable(touch_threshold_reg))
        else $error("threshold changed without a write");
    a_cfg_hold_back: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_wr |=> $stable(cfg_reg))
        else $error("settings changed without a write");
    a_push_only_ready: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> push_ready)
        else $error("summary pushed into a full queue");
`endif

endmodule
`default_nettype wire
